// ===== design/midi_active_note_tracker_defines.svh =====
// assertion macros shared by the checker
`ifndef MIDI_ACTIVE_NOTE_TRACKER_DEFINES_SVH
`define MIDI_ACTIVE_NOTE_TRACKER_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define MANT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MANT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/mant_pkg.sv =====
package mant_pkg;

	localparam int NUM_CHANNELS = 16;
	localparam int NUM_NOTES    = 128;

	localparam int CH_AW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int NT_AW  = $clog2(NUM_NOTES);
	localparam int PAN_W  = $clog2(2 * NUM_CHANNELS);
	localparam int CNT_W  = 16;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [6:0] CTRL_ALL_SOUND_OFF = 7'd120;
	localparam logic [6:0] CTRL_ALL_NOTES_OFF = 7'd123;

	localparam int QUEUE_DEPTH = 2;
	localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] CMD_NOTE_ON  = 3'd0;
	localparam logic [2:0] CMD_NOTE_OFF = 3'd1;
	localparam logic [2:0] CMD_QUERY    = 3'd2;
	localparam logic [2:0] CMD_FLUSH    = 3'd3;
	localparam logic [2:0] CMD_PANIC    = 3'd4;

	localparam logic [1:0] KIND_STATUS   = 2'd0;
	localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
	localparam logic [1:0] KIND_CC       = 2'd2;

	typedef struct packed {
		logic [2:0] command;
		logic [3:0] chan;
		logic [6:0] note_number;
	} mant_cmd_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [3:0] out_channel;
		logic [6:0] data_byte;
		logic       note_held;
		logic       any_active;
		logic       last;
	} mant_res_t;

	typedef enum logic [2:0] {
		OP_SET,
		OP_CLR,
		OP_QUERY,
		OP_FLUSH,
		OP_PANIC,
		OP_NOP
	} mant_op_t;

	typedef struct packed {
		mant_op_t         op;
		logic [CH_AW-1:0] chan;
		logic [NT_AW-1:0] note;
	} mant_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} mant_q_status_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_READ,
		B_EXEC,
		B_FLUSH_RD,
		B_FLUSH_CHK,
		B_PANIC
	} mant_bstate_t;

endpackage

// ===== design/mant_front.sv =====
module mant_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  mant_pkg::mant_cmd_t    item,
	input  mant_pkg::mant_q_status_t q_status,
	output logic                   push,
	output mant_pkg::mant_item_t   push_item
);
	import mant_pkg::*;

	logic       slot_vld_q;
	mant_item_t slot_q;
	mant_item_t cls;
	logic       in_rng;
	logic       accept;

	assign push      = slot_vld_q && !q_status.full;
	assign push_item = slot_q;
	assign busy      = slot_vld_q && q_status.full;
	assign accept    = start && !busy;

	// range check against the table size
	assign in_rng = ({1'b0, item.chan} < 5'(NUM_CHANNELS)) &&
		({1'b0, item.note_number} < 8'(NUM_NOTES));

	always_comb begin
		cls.chan = item.chan[CH_AW-1:0];
		cls.note = item.note_number[NT_AW-1:0];
		case (item.command)
			CMD_NOTE_ON:  cls.op = in_rng ? OP_SET : OP_NOP;
			CMD_NOTE_OFF: cls.op = in_rng ? OP_CLR : OP_NOP;
			CMD_QUERY:    cls.op = in_rng ? OP_QUERY : OP_NOP;
			CMD_FLUSH:    cls.op = OP_FLUSH;
			CMD_PANIC:    cls.op = OP_PANIC;
			default:      cls.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= 1'b0;
		end else if (accept) begin
			slot_vld_q <= 1'b1;
		end else if (push) begin
			slot_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q <= cls;
		end
	end

endmodule

// ===== design/mant_fifo.sv =====
module mant_fifo (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  mant_pkg::mant_item_t     push_item,
	input  logic                     pop,
	output mant_pkg::mant_item_t     head,
	output mant_pkg::mant_q_status_t status
);
	import mant_pkg::*;

	mant_item_t      entry_q [QUEUE_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign status.full  = (count_q == QC_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;
	assign head    = entry_q[rd_ptr_q];

	function automatic logic [QP_W-1:0] ptr_inc(input logic [QP_W-1:0] p);
		return (p == QP_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== design/mant_back.sv =====
module mant_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mant_pkg::mant_item_t     head,
	input  mant_pkg::mant_q_status_t q_status,
	output logic                     pop,
	output logic                     done,
	output mant_pkg::mant_res_t      result
);
	import mant_pkg::*;

	logic [NUM_NOTES-1:0] mem [NUM_CHANNELS];
	logic [NUM_NOTES-1:0] rd_row_q;
	logic                 rd_vld_q;
	logic [NUM_CHANNELS-1:0] row_vld_q;

	mant_bstate_t     state_q, state_d;
	mant_op_t         op_q;
	logic [CH_AW-1:0] ch_q;
	logic [NT_AW-1:0] nt_q;
	logic [CH_AW-1:0] scan_q, scan_d;
	logic [PAN_W-1:0] pan_q, pan_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	logic                 load;
	logic                 rd_en;
	logic [CH_AW-1:0]     rd_addr;
	logic                 wr_en;
	logic [CH_AW-1:0]     wr_addr;
	logic [NUM_NOTES-1:0] wr_data;
	logic                 clr_all;
	logic                 emit;
	mant_res_t            emit_res;

	logic [NUM_NOTES-1:0] row_eff;
	logic [NUM_NOTES-1:0] note_mask;
	logic [NUM_NOTES-1:0] low_bit;
	logic [NT_AW-1:0]     low_idx;
	logic                 bitv;

	// rows never written read as zero
	assign row_eff   = rd_vld_q ? rd_row_q : '0;
	assign note_mask = NUM_NOTES'(1) << nt_q;
	assign bitv      = row_eff[nt_q];
	assign low_bit   = row_eff & (~row_eff + 1'b1);

	always_comb begin
		low_idx = '0;
		for (int i = 0; i < NUM_NOTES; i++) begin
			low_idx = low_idx | (low_bit[i] ? NT_AW'(i) : '0);
		end
	end

	always_comb begin
		state_d  = state_q;
		scan_d   = scan_q;
		pan_d    = pan_q;
		cnt_d    = cnt_q;
		load     = 1'b0;
		pop      = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = ch_q;
		wr_en    = 1'b0;
		wr_addr  = ch_q;
		wr_data  = row_eff;
		clr_all  = 1'b0;
		emit     = 1'b0;
		emit_res = '{event_kind: KIND_STATUS, out_channel: 4'd0, data_byte: 7'd0,
			note_held: 1'b0, any_active: (cnt_q != '0), last: 1'b1};
		case (state_q)
			B_IDLE: begin
				if (!q_status.empty) begin
					pop  = 1'b1;
					load = 1'b1;
					case (head.op)
						OP_NOP: begin
							emit = 1'b1;
						end
						OP_PANIC: begin
							pan_d   = '0;
							state_d = B_PANIC;
						end
						OP_FLUSH: begin
							scan_d  = '0;
							state_d = B_FLUSH_RD;
						end
						default: begin
							state_d = B_READ;
						end
					endcase
				end
			end
			B_READ: begin
				rd_en   = 1'b1;
				rd_addr = ch_q;
				state_d = B_EXEC;
			end
			B_EXEC: begin
				emit    = 1'b1;
				state_d = B_IDLE;
				case (op_q)
					OP_SET: begin
						wr_en   = 1'b1;
						wr_data = row_eff | note_mask;
						if (cnt_q != CNT_MAX) begin
							cnt_d = cnt_q + 1'b1;
						end
					end
					OP_CLR: begin
						if (bitv) begin
							wr_en   = 1'b1;
							wr_data = row_eff & ~note_mask;
							if (cnt_q != '0) begin
								cnt_d = cnt_q - 1'b1;
							end
						end
					end
					OP_QUERY: begin
						emit_res.note_held = bitv;
					end
					default: begin
					end
				endcase
				emit_res.any_active = (cnt_d != '0);
			end
			B_FLUSH_RD: begin
				rd_en   = 1'b1;
				rd_addr = scan_q;
				state_d = B_FLUSH_CHK;
			end
			B_FLUSH_CHK: begin
				if (row_eff != '0) begin
					wr_en   = 1'b1;
					wr_addr = scan_q;
					wr_data = row_eff & ~low_bit;
					emit    = 1'b1;
					emit_res.event_kind  = KIND_NOTE_OFF;
					emit_res.out_channel = 4'(scan_q);
					emit_res.data_byte   = 7'(low_idx);
					state_d = B_IDLE;
				end else if (scan_q == CH_AW'(NUM_CHANNELS - 1)) begin
					// nothing held anywhere: counter forced to zero
					cnt_d   = '0;
					emit    = 1'b1;
					emit_res.any_active = 1'b0;
					state_d = B_IDLE;
				end else begin
					scan_d  = scan_q + 1'b1;
					state_d = B_FLUSH_RD;
				end
			end
			B_PANIC: begin
				clr_all = 1'b1;
				cnt_d   = '0;
				emit    = 1'b1;
				emit_res.event_kind  = KIND_CC;
				emit_res.out_channel = 4'(pan_q >> 1);
				emit_res.data_byte   = pan_q[0] ? CTRL_ALL_NOTES_OFF : CTRL_ALL_SOUND_OFF;
				emit_res.any_active  = 1'b0;
				emit_res.last        = (pan_q == PAN_W'(2 * NUM_CHANNELS - 1));
				if (emit_res.last) begin
					state_d = B_IDLE;
				end else begin
					pan_d = pan_q + 1'b1;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			scan_q    <= '0;
			pan_q     <= '0;
			cnt_q     <= '0;
			row_vld_q <= '0;
			op_q      <= OP_NOP;
			done      <= 1'b0;
		end else begin
			state_q <= state_d;
			scan_q  <= scan_d;
			pan_q   <= pan_d;
			cnt_q   <= cnt_d;
			done    <= emit;
			if (load) begin
				op_q <= head.op;
			end
			if (clr_all) begin
				row_vld_q <= '0;
			end else if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ch_q <= head.chan;
			nt_q <= head.note;
		end
		if (emit) begin
			result <= emit_res;
		end
	end

	// row store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_row_q <= mem[rd_addr];
			rd_vld_q <= row_vld_q[rd_addr];
		end
	end

endmodule

// ===== design/midi_active_note_tracker.sv =====
// done rises once the back sequencer finishes each accepted command: note_on, note_off
// and query pass through B_READ and B_EXEC, unknown commands report straight from idle,
// flush_step reads the channels in turn until one holds a note; panic emits a burst of
// CC words, All Sound Off then All Notes Off per channel, the final one marked last
// commands queue while the back works; busy when the slot and the queue are both full
// reset: asynchronous, clears the held table, the counter, the queue and all strobes
module midi_active_note_tracker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mant_pkg::mant_cmd_t item,
	output logic                done,
	output mant_pkg::mant_res_t result
);
	import mant_pkg::*;

	mant_q_status_t q_status;
	logic           push;
	mant_item_t     push_item;
	logic           pop;
	mant_item_t     head;

	mant_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.q_status  (q_status),
		.push      (push),
		.push_item (push_item)
	);

	mant_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	mant_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.done     (done),
		.result   (result)
	);

endmodule

// ===== design/mant_checker.sv =====
`include "midi_active_note_tracker_defines.svh"

module mant_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                done,
	input mant_pkg::mant_res_t result
);
	import mant_pkg::*;

	`MANT_ASSERT_NOW(a_status_clean, done && result.event_kind == KIND_STATUS, result.out_channel == 4'd0 && result.data_byte == 7'd0, "status word carries a message field")
	`MANT_ASSERT_NOW(a_held_only_status, done && result.note_held, result.event_kind == KIND_STATUS, "note_held set on a message word")
	`MANT_ASSERT_NEXT(a_panic_burst, done && result.event_kind == KIND_CC && !result.last, done && result.event_kind == KIND_CC, "panic burst broken")
	`MANT_ASSERT_NOW(a_panic_end, done && result.event_kind == KIND_CC && result.last, !result.any_active && result.data_byte == CTRL_ALL_NOTES_OFF, "panic ends wrongly")
	`MANT_ASSERT_NOW(a_noteoff_single, done && result.event_kind == KIND_NOTE_OFF, result.last, "flush note-off not final")

endmodule

bind midi_active_note_tracker mant_checker u_chk (.*);
